@@ rtl/core/utc_pkg.sv @@
// Types and byte constants shared by the UTF-8 text canonicalizer.
`timescale 1ns / 1ps

package utc_pkg;

	// Byte constants of the whitespace and Latin-1 sequences and of ASCII lowercasing
	localparam logic [7:0] B_SPACE    = 8'h20;
	localparam logic [7:0] B_TAB      = 8'h09;
	localparam logic [7:0] B_CR       = 8'h0D;
	localparam logic [7:0] B_C2       = 8'hC2;
	localparam logic [7:0] B_C3       = 8'hC3;
	localparam logic [7:0] B_E2       = 8'hE2;
	localparam logic [7:0] B_E3       = 8'hE3;
	localparam logic [7:0] B_80       = 8'h80;
	localparam logic [7:0] B_A0       = 8'hA0;
	localparam logic [7:0] B_A8       = 8'hA8;
	localparam logic [7:0] B_A9       = 8'hA9;
	localparam logic [7:0] B_9E       = 8'h9E;
	localparam logic [7:0] B_97       = 8'h97;
	localparam logic [7:0] B_UPPER_A  = 8'h41;
	localparam logic [7:0] B_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	// Most result words one input word can produce
	localparam int MAX_RES = 4;

	// One result word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last;
	} item_t;

	// Running state of one scan pass
	typedef struct packed {
		item_t [MAX_RES-1:0] items;
		logic [2:0]          n;
		logic                sp;
		logic                wa;
	} scan_t;

endpackage

@@ rtl/core/utf8_text_canonicalizer.sv @@
// UTF-8 text canonicalizer: whitespace folding and lowercasing, one byte per word.
`timescale 1ns / 1ps

// Takes text one byte per input word (s_tdata) and gives its canonical form as
// output words. s_tlast high ends the text: held prefix bytes are flushed and a
// final word with m_tlast high and no byte (m_tuser low) follows; state then
// returns to reset. An accepted word waits in the input register, is resolved
// there, and its results (zero to four words) are loaded into the result
// register once it is empty or handing out its last word. The result register
// drains one word per cycle while m_tready is high; a byte that gives one
// word or none keeps that rate, and one that gives more stalls the input.
module utf8_text_canonicalizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic       s_tlast,  // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tuser,  // has_byte
	output logic       m_tlast   // last
);

	// Input register
	logic [7:0] data_s1;
	logic       eot_s1;
	logic       valid_s1;

	// Canonicalizer state
	logic [7:0] held_q [2];
	logic [1:0] held_cnt_q;
	logic       sp_q;
	logic       wa_q;

	// Result register
	utc_pkg::item_t res_q [utc_pkg::MAX_RES];
	logic [2:0]     res_rem_q;
	logic [1:0]     res_idx_q;

	logic           take;
	logic           buf_free;
	logic           consume;

	utc_pkg::scan_t scan;
	logic [7:0]     nh0;
	logic [7:0]     nh1;
	logic [1:0]     nh_cnt;

	// Append one result word
	function automatic utc_pkg::scan_t put_item(utc_pkg::scan_t s, logic [7:0] b,
		logic has, logic fin);
		utc_pkg::scan_t r;
		r = s;
		if (r.n < 3'(utc_pkg::MAX_RES)) begin
			r.items[r.n[1:0]].out_byte = has ? b : 8'h00;
			r.items[r.n[1:0]].has_byte = has;
			r.items[r.n[1:0]].last     = fin;
			r.n = r.n + 3'd1;
		end
		return r;
	endfunction

	// Write a text byte, preceded by a pending space
	function automatic utc_pkg::scan_t put_text(utc_pkg::scan_t s, logic [7:0] b);
		utc_pkg::scan_t r;
		r = s;
		if (r.sp) begin
			r = put_item(r, utc_pkg::B_SPACE, 1'b1, 1'b0);
			r.sp = 1'b0;
		end
		r = put_item(r, b, 1'b1, 1'b0);
		r.wa = 1'b1;
		return r;
	endfunction

	// Handshakes
	assign take     = m_tvalid && m_tready;
	assign buf_free = (res_rem_q == 3'd0) || (res_rem_q == 3'd1 && m_tready);
	assign consume  = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || buf_free;

	// Resolve the held bytes plus the new byte
	always_comb begin
		logic [7:0] bufb [4];
		logic [1:0] len;
		logic [2:0] pos;
		logic       stop;
		logic       done;
		logic       fin;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;

		fin  = eot_s1;
		bufb[0] = 8'h00;
		bufb[1] = 8'h00;
		bufb[2] = 8'h00;
		bufb[3] = 8'h00;
		len  = 2'd0;
		case (held_cnt_q)
			2'd0: begin
				bufb[0] = data_s1;
			end
			2'd1: begin
				bufb[0] = held_q[0];
				bufb[1] = data_s1;
			end
			default: begin
				bufb[0] = held_q[0];
				bufb[1] = held_q[1];
				bufb[2] = data_s1;
			end
		endcase
		len = (held_cnt_q == 2'd3 ? 2'd2 : held_cnt_q) + {1'b0, !fin};

		scan       = '0;
		scan.sp    = sp_q;
		scan.wa    = wa_q;
		pos        = 3'd0;
		stop       = 1'b0;
		b0         = 8'h00;
		b1         = 8'h00;
		b2         = 8'h00;

		// Up to three sequences in one pass, each at least one byte long
		for (int k = 0; k < 3; k++) begin
			done = 1'b0;
			if (!stop && pos < {1'b0, len}) begin
				b0 = bufb[pos[1:0]];
				b1 = (pos + 3'd1 < {1'b0, len}) ? bufb[2'(pos + 3'd1)] : 8'h00;
				b2 = (pos + 3'd2 < {1'b0, len}) ? bufb[2'(pos + 3'd2)] : 8'h00;
				if (b0 == utc_pkg::B_SPACE ||
					(b0 >= utc_pkg::B_TAB && b0 <= utc_pkg::B_CR)) begin
					scan.sp = scan.sp | scan.wa;
					pos     = pos + 3'd1;
					done    = 1'b1;
				end else if (b0 == utc_pkg::B_C2 || b0 == utc_pkg::B_C3 ||
					b0 == utc_pkg::B_E2 || b0 == utc_pkg::B_E3) begin
					if (pos + 3'd1 >= {1'b0, len} && !fin) begin
						stop = 1'b1;
					end else if (b0 == utc_pkg::B_C2 && b1 == utc_pkg::B_A0) begin
						scan.sp = scan.sp | scan.wa;
						pos     = pos + 3'd2;
						done    = 1'b1;
					end else begin
						if ((b0 == utc_pkg::B_E2 || b0 == utc_pkg::B_E3) &&
							b1 == utc_pkg::B_80) begin
							if (pos + 3'd2 >= {1'b0, len} && !fin) begin
								stop = 1'b1;
							end else if ((b0 == utc_pkg::B_E2 &&
								(b2 == utc_pkg::B_A8 || b2 == utc_pkg::B_A9)) ||
								(b0 == utc_pkg::B_E3 && b2 == utc_pkg::B_80)) begin
								scan.sp = scan.sp | scan.wa;
								pos     = pos + 3'd3;
								done    = 1'b1;
							end
						end
						if (!stop && !done && b0 == utc_pkg::B_C3 &&
							b1 >= utc_pkg::B_80 && b1 <= utc_pkg::B_9E &&
							b1 != utc_pkg::B_97) begin
							scan = put_text(scan, utc_pkg::B_C3);
							scan = put_text(scan, b1 + utc_pkg::CASE_DELTA);
							pos  = pos + 3'd2;
							done = 1'b1;
						end
					end
				end
				// Plain byte, ASCII capitals lowercased
				if (!stop && !done) begin
					if (b0 >= utc_pkg::B_UPPER_A && b0 <= utc_pkg::B_UPPER_Z)
						scan = put_text(scan, b0 + utc_pkg::CASE_DELTA);
					else
						scan = put_text(scan, b0);
					pos = pos + 3'd1;
				end
			end
		end

		// Keep the unresolved tail
		nh0    = bufb[pos[1:0]];
		nh1    = bufb[2'(pos + 3'd1)];
		nh_cnt = 2'({1'b0, len} - pos);

		// End of text: final word, back to reset state
		if (fin) begin
			scan    = put_item(scan, 8'h00, 1'b0, 1'b1);
			scan.sp = 1'b0;
			scan.wa = 1'b0;
			nh_cnt  = 2'd0;
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	// Advance the canonicalizer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			sp_q       <= 1'b0;
			wa_q       <= 1'b0;
		end else if (consume) begin
			held_cnt_q <= nh_cnt;
			sp_q       <= scan.sp;
			wa_q       <= scan.wa;
		end
	end

	// Hold prefix bytes
	always_ff @(posedge clk) begin
		if (consume) begin
			held_q[0] <= nh0;
			held_q[1] <= nh1;
		end
	end

	// Result register control: load a batch or drain one word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_rem_q <= 3'd0;
			res_idx_q <= 2'd0;
		end else if (consume) begin
			res_rem_q <= scan.n;
			res_idx_q <= 2'd0;
		end else if (take) begin
			res_rem_q <= res_rem_q - 3'd1;
			res_idx_q <= res_idx_q + 2'd1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (consume) begin
			for (int i = 0; i < utc_pkg::MAX_RES; i++)
				res_q[i] <= scan.items[i];
		end
	end

	// Drive the output word
	assign m_tvalid = (res_rem_q != 3'd0);
	assign m_tdata  = res_q[res_idx_q].out_byte;
	assign m_tuser  = res_q[res_idx_q].has_byte;
	assign m_tlast  = res_q[res_idx_q].last;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the UTF-8 text canonicalizer.
`timescale 1ns / 1ps

module tb_top;

	localparam int N_DIR       = 25;
	localparam int N_RAND      = 155;
	localparam int IDLE_PCT    = 28;
	localparam int CYCLE_LIMIT = 100000;

	localparam utc_pkg::item_t NO_WORD  = '{8'h00, 1'b0, 1'b0};
	localparam utc_pkg::item_t END_WORD = '{8'h00, 1'b0, 1'b1};

	// One directed row: input word, and typed results where n_typed >= 0
	typedef struct {
		logic [7:0]     dbyte;
		bit             eot;
		int             n_typed;
		utc_pkg::item_t w0;
		utc_pkg::item_t w1;
	} dir_row_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	// Canonicalizer state as predicted
	logic [7:0] held_pfx [2];
	int         held_n;
	bit         space_due;
	bit         text_started;

	utc_pkg::item_t step_words[$];  // words of the current input word
	utc_pkg::item_t due_words[$];   // words still awaited from the block
	logic [7:0]     rnd_bytes[$];
	bit             rnd_ends[$];
	bit             steady = 1'b0;  // no idling on either side while set
	int             errors = 0;
	int             cycles = 0;

	utf8_text_canonicalizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),    // [7:0] data_byte
		.s_tlast(s_tlast),    // end_of_text
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),    // [7:0] out_byte
		.m_tuser(m_tuser),    // has_byte
		.m_tlast(m_tlast)     // last
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words due", cycles, due_words.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// Emit one text byte, preceded by the pending space if any
	function automatic void emit_text(input logic [7:0] b);
		if (space_due) begin
			step_words.push_back('{utc_pkg::B_SPACE, 1'b1, 1'b0});
			space_due = 1'b0;
		end
		step_words.push_back('{b, 1'b1, 1'b0});
		text_started = 1'b1;
	endfunction

	// Whitespace only counts once some text has been written
	function automatic void note_space();
		if (text_started)
			space_due = 1'b1;
	endfunction

	// Resolve the held bytes plus the new one; keep an unresolved tail
	function automatic void canon_scan(input logic [7:0] bufb [3], input int len,
		input bit fin);
		int         pos;
		bit         stop;
		bit         done;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		pos  = 0;
		stop = 1'b0;
		while (pos < len && !stop) begin
			b0   = bufb[pos];
			done = 1'b0;
			if (b0 == utc_pkg::B_SPACE ||
				(b0 >= utc_pkg::B_TAB && b0 <= utc_pkg::B_CR)) begin
				note_space();
				pos += 1;
				done = 1'b1;
			end else if (b0 == utc_pkg::B_C2 || b0 == utc_pkg::B_C3 ||
				b0 == utc_pkg::B_E2 || b0 == utc_pkg::B_E3) begin
				if (pos + 1 >= len && !fin) begin
					stop = 1'b1;
				end else begin
					b1 = (pos + 1 < len) ? bufb[pos + 1] : 8'h00;
					if (b0 == utc_pkg::B_C2 && b1 == utc_pkg::B_A0) begin
						note_space();
						pos += 2;
						done = 1'b1;
					end else if ((b0 == utc_pkg::B_E2 || b0 == utc_pkg::B_E3) &&
						b1 == utc_pkg::B_80) begin
						if (pos + 2 >= len && !fin) begin
							stop = 1'b1;
						end else begin
							b2 = (pos + 2 < len) ? bufb[pos + 2] : 8'h00;
							if ((b0 == utc_pkg::B_E2 &&
								(b2 == utc_pkg::B_A8 || b2 == utc_pkg::B_A9)) ||
								(b0 == utc_pkg::B_E3 && b2 == utc_pkg::B_80)) begin
								note_space();
								pos += 3;
								done = 1'b1;
							end
						end
					end
					// Latin-1 capital: lowercase the second byte
					if (!done && !stop && b0 == utc_pkg::B_C3 && b1 >= utc_pkg::B_80 &&
						b1 <= utc_pkg::B_9E && b1 != utc_pkg::B_97) begin
						emit_text(utc_pkg::B_C3);
						emit_text(b1 + utc_pkg::CASE_DELTA);
						pos += 2;
						done = 1'b1;
					end
				end
			end
			// Plain byte, a prefix that failed included
			if (!done && !stop) begin
				if (b0 >= utc_pkg::B_UPPER_A && b0 <= utc_pkg::B_UPPER_Z)
					emit_text(b0 + utc_pkg::CASE_DELTA);
				else
					emit_text(b0);
				pos += 1;
			end
		end
		held_n = 0;
		while (pos < len && held_n < 2) begin
			held_pfx[held_n] = bufb[pos];
			held_n++;
			pos++;
		end
	endfunction

	function automatic void clear_state();
		held_n       = 0;
		space_due    = 1'b0;
		text_started = 1'b0;
	endfunction

	// Predict the words of one accepted input word into step_words
	function automatic void canon_step(input logic [7:0] dbyte, input bit eot);
		logic [7:0] bufb [3];
		int         len;
		step_words.delete();
		bufb = '{8'h00, 8'h00, 8'h00};
		len  = 0;
		for (int i = 0; i < held_n; i++) begin
			bufb[len] = held_pfx[i];
			len++;
		end
		if (!eot) begin
			bufb[len] = dbyte;
			len++;
		end
		canon_scan(bufb, len, eot);
		if (eot) begin
			step_words.push_back(END_WORD);
			clear_state();
		end
	endfunction

	// Offer one input word, then queue its expected words on acceptance
	task automatic send_word(input logic [7:0] dbyte, input bit eot, input int n_typed,
		input utc_pkg::item_t w0, input utc_pkg::item_t w1);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			s_tdata  = 8'($urandom_range(0, 255));
			s_tlast  = 1'($urandom_range(0, 1));
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = dbyte;
		s_tlast  = eot;
		do
			@(posedge clk);
		while (!s_tready);
		canon_step(dbyte, eot);
		if (n_typed < 0) begin
			foreach (step_words[i])
				due_words.push_back(step_words[i]);
		end else begin
			if (n_typed >= 1)
				due_words.push_back(w0);
			if (n_typed >= 2)
				due_words.push_back(w1);
		end
		@(negedge clk);
	endtask

	// Hold the input until the block has drained
	task automatic pause_until_drained();
		s_tvalid = 1'b0;
		do
			@(negedge clk);
		while (due_words.size() != 0);
	endtask

	function automatic void add_word(input logic [7:0] b, input bit eot);
		rnd_bytes.push_back(b);
		rnd_ends.push_back(eot);
	endfunction

	function automatic logic [7:0] pick_space();
		return ($urandom_range(0, 5) == 0) ? utc_pkg::B_SPACE :
			8'($urandom_range(utc_pkg::B_TAB, utc_pkg::B_CR));
	endfunction

	function automatic logic [7:0] pick_prefix();
		case ($urandom_range(0, 3))
			0: return utc_pkg::B_C2;
			1: return utc_pkg::B_C3;
			2: return utc_pkg::B_E2;
			default: return utc_pkg::B_E3;
		endcase
	endfunction

	// Stall the result side at random
	always @(negedge clk)
		m_tready = steady || ($urandom_range(0, 99) >= IDLE_PCT);

	// Compare every accepted word with the oldest expectation
	always @(posedge clk) begin
		utc_pkg::item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word byte=%02h has=%0b last=%0b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = due_words.pop_front();
				if (m_tdata !== want.out_byte || m_tuser !== want.has_byte ||
					m_tlast !== want.last)
					report_mismatch($sformatf(
						"got byte=%02h has=%0b last=%0b, want byte=%02h has=%0b last=%0b",
						m_tdata, m_tuser, m_tlast, want.out_byte, want.has_byte,
						want.last));
			end
		end
	end

	initial begin : main
		dir_row_t   dir_rows [N_DIR];
		int         pick;
		logic [7:0] pfx;

		dir_rows = '{
			'{utc_pkg::B_SPACE,   1'b0, -1, NO_WORD, NO_WORD},  // leading space, dropped
			'{utc_pkg::B_UPPER_A, 1'b0,  1, '{8'h61, 1'b1, 1'b0}, NO_WORD},
			'{utc_pkg::B_TAB,     1'b0, -1, NO_WORD, NO_WORD},
			'{utc_pkg::B_C2,      1'b0, -1, NO_WORD, NO_WORD},  // no-break space
			'{utc_pkg::B_A0,      1'b0, -1, NO_WORD, NO_WORD},
			'{utc_pkg::B_UPPER_Z, 1'b0,  2, '{utc_pkg::B_SPACE, 1'b1, 1'b0},
				'{8'h7A, 1'b1, 1'b0}},
			'{utc_pkg::B_E2,      1'b0, -1, NO_WORD, NO_WORD},  // paragraph separator
			'{utc_pkg::B_80,      1'b0, -1, NO_WORD, NO_WORD},
			'{utc_pkg::B_A9,      1'b0, -1, NO_WORD, NO_WORD},
			'{utc_pkg::B_E3,      1'b0, -1, NO_WORD, NO_WORD},  // ideographic space
			'{utc_pkg::B_80,      1'b0, -1, NO_WORD, NO_WORD},
			'{utc_pkg::B_80,      1'b0, -1, NO_WORD, NO_WORD},
			'{utc_pkg::B_C3,      1'b0, -1, NO_WORD, NO_WORD},  // top Latin-1 capital
			'{utc_pkg::B_9E,      1'b0, -1, NO_WORD, NO_WORD},
			'{utc_pkg::B_C3,      1'b0, -1, NO_WORD, NO_WORD},  // multiplication sign kept
			'{utc_pkg::B_97,      1'b0, -1, NO_WORD, NO_WORD},
			'{utc_pkg::B_E2,      1'b0, -1, NO_WORD, NO_WORD},  // broken prefix, rescanned
			'{utc_pkg::B_UPPER_A, 1'b0, -1, NO_WORD, NO_WORD},
			'{8'h00,              1'b0, -1, NO_WORD, NO_WORD},  // zero byte passes through
			'{8'hFF,              1'b0,  1, '{8'hFF, 1'b1, 1'b0}, NO_WORD},
			'{utc_pkg::B_CR,      1'b0, -1, NO_WORD, NO_WORD},
			'{8'h00,              1'b1,  1, END_WORD, NO_WORD}, // trailing space dropped
			'{utc_pkg::B_C3,      1'b0, -1, NO_WORD, NO_WORD},  // prefix cut off by end
			'{8'hFF,              1'b1,  2, '{utc_pkg::B_C3, 1'b1, 1'b0}, END_WORD},
			'{8'h00,              1'b1,  1, END_WORD, NO_WORD}  // empty text
		};

		// Build the random text: mostly well-formed runs, some noise
		while (rnd_bytes.size() < N_RAND) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				add_word(8'($urandom_range(0, 255)), 1'b1);
			end else if (pick < 28) begin
				add_word(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
			end else if (pick < 38) begin
				add_word(8'($urandom_range(utc_pkg::B_UPPER_A, utc_pkg::B_UPPER_Z)), 1'b0);
			end else if (pick < 48) begin
				add_word(pick_space(), 1'b0);
			end else if (pick < 52) begin
				add_word(pick_space(), 1'b0);
				add_word(pick_space(), 1'b0);
				add_word(pick_space(), 1'b0);
			end else if (pick < 57) begin
				add_word(utc_pkg::B_C2, 1'b0);
				add_word(utc_pkg::B_A0, 1'b0);
			end else if (pick < 62) begin
				add_word(utc_pkg::B_E2, 1'b0);
				add_word(utc_pkg::B_80, 1'b0);
				add_word($urandom_range(0, 1) ? utc_pkg::B_A8 : utc_pkg::B_A9, 1'b0);
			end else if (pick < 66) begin
				add_word(utc_pkg::B_E3, 1'b0);
				add_word(utc_pkg::B_80, 1'b0);
				add_word(utc_pkg::B_80, 1'b0);
			end else if (pick < 75) begin
				add_word(utc_pkg::B_C3, 1'b0);
				add_word(8'($urandom_range(8'h80, 8'h9F)), 1'b0);
			end else if (pick < 85) begin
				// Broken sequence: prefix, maybe the middle byte, then anything
				pfx = pick_prefix();
				add_word(pfx, 1'b0);
				if ((pfx == utc_pkg::B_E2 || pfx == utc_pkg::B_E3) && $urandom_range(0, 1))
					add_word(utc_pkg::B_80, 1'b0);
				add_word(8'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 90) begin
				// Prefix left open at end of text
				add_word(pick_prefix(), 1'b0);
				if ($urandom_range(0, 1))
					add_word(utc_pkg::B_80, 1'b0);
				add_word(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				add_word(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		add_word(8'($urandom_range(0, 255)), 1'b1);

		// Reset once
		clear_state();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].dbyte, dir_rows[i].eot, dir_rows[i].n_typed,
				dir_rows[i].w0, dir_rows[i].w1);
		pause_until_drained();

		foreach (rnd_bytes[i]) begin
			steady = (i >= 40 && i < 100);
			if (i == 130)
				pause_until_drained();
			send_word(rnd_bytes[i], rnd_ends[i], -1, NO_WORD, NO_WORD);
		end
		s_tvalid = 1'b0;
		steady   = 1'b0;

		// Drain, then wait for stray words
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (errors == 0 && due_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
